// ----- src/frsn_pkg.sv -----
// shared types, codes and constants of the factor row-sum normalizer
package frsn_pkg;

    localparam int VAL_W     = 32;
    localparam int SUM_W     = 48;
    localparam int OIDX_W    = 16;
    localparam int FIDX_W    = 4;
    localparam int NF_W      = 5;
    localparam int SIZE_W    = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int REQ_W     = 2;
    localparam int ST_W      = 2;
    localparam int SEL_W     = 2;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = 5;
    // largest factor count the 4-bit factor index can reach
    localparam int FIDX_SPAN = 16;

    localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SCALE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NORM  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_N_FACTORS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_N_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_N_COLS    = 2'd2;

    localparam logic [SEL_W-1:0] OUT_RANGE = 2'd0;
    localparam logic [SEL_W-1:0] OUT_MUL   = 2'd1;
    localparam logic [SEL_W-1:0] OUT_DIV   = 2'd2;

    localparam logic [NF_W-1:0]   N_FACTORS_RST = 5'd16;
    localparam logic [SIZE_W-1:0] SIZE_RST      = 17'h10000;
    localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0]  ONE_Q16       = 48'h0000_0001_0000;
    localparam logic [VAL_W-1:0]  VAL_MAX       = {VAL_W{1'b1}};
    localparam logic [CNT_W-1:0]  LAST_STEP     = 5'd31;

    typedef struct packed {
        logic             capture;
        logic             mul_lo;
        logic             mul_hi;
        logic             div_init;
        logic             div_step;
        logic             load_out;
        logic [SEL_W-1:0] out_sel;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             idx_ok;
        logic             div_ovf;
        logic             out_free;
    } stat_t;

endpackage

// ----- src/frsn_ctrl.sv -----
// controller state machine: sequences capture, multiply, divide and result load
module frsn_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  frsn_pkg::stat_t stat,
    output frsn_pkg::cmd_t  cmd
);
    import frsn_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL_LO = 3'd1;
    localparam logic [2:0] S_MUL_HI = 3'd2;
    localparam logic [2:0] S_DIVCHK = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.out_sel  = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (stat.req)
                        REQ_SCALE:
                        begin
                            if (stat.idx_ok)
                            begin
                                state_next = S_MUL_LO;
                                sel_next   = OUT_MUL;
                            end
                            else
                            begin
                                state_next = S_DONE;
                                sel_next   = OUT_RANGE;
                            end
                        end
                        REQ_NORM:
                        begin
                            if (stat.idx_ok)
                            begin
                                state_next = S_DIVCHK;
                                sel_next   = OUT_DIV;
                            end
                            else
                            begin
                                state_next = S_DONE;
                                sel_next   = OUT_RANGE;
                            end
                        end
                        default:
                        begin
                            // accumulate and clear finish in the capture cycle
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_DONE;
            end
            S_DIVCHK:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                // quotient that cannot fit 32 bits skips the iterations
                state_next   = stat.div_ovf ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= OUT_RANGE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- src/frsn_dp.sv -----
// datapath: size registers, factor sums, shared multiplier, radix-2 divider, result register
module frsn_dp #(
    parameter int MAX_FACTORS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [frsn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frsn_pkg::CFG_W-1:0]      cfg_data,
    input  logic [frsn_pkg::REQ_W-1:0]      req_type,
    input  logic [frsn_pkg::FIDX_W-1:0]     factor_index,
    input  logic [frsn_pkg::OIDX_W-1:0]     other_index,
    input  logic [frsn_pkg::VAL_W-1:0]      elem_value,
    input  frsn_pkg::cmd_t                  cmd,
    output frsn_pkg::stat_t                 stat,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [frsn_pkg::VAL_W-1:0]      result_value,
    output logic [frsn_pkg::ST_W-1:0]       status
);
    import frsn_pkg::*;

    // only the first sixteen factors are reachable through the factor index
    localparam int SUM_DEPTH = (MAX_FACTORS < FIDX_SPAN) ? MAX_FACTORS : FIDX_SPAN;
    localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam logic [NF_W-1:0] FACTOR_LIMIT = NF_W'(SUM_DEPTH);

    logic [NF_W-1:0]   n_factors_reg;
    logic [SIZE_W-1:0] n_rows_reg;
    logic [SIZE_W-1:0] n_cols_reg;

    logic [SUM_W-1:0]  sums_reg [SUM_DEPTH];

    logic [VAL_W-1:0]  v_reg;
    logic [SUM_W-1:0]  k_reg;
    logic              ssat_reg;
    logic [SUM_W-1:0]  lo_reg;
    logic [SUM_W-1:0]  hi_reg;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  quo_reg, quo_next;
    logic              ovf_reg;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  res_reg, res_next;
    logic [ST_W-1:0]   st_reg, st_next;

    logic [SUM_AW-1:0] sel;
    logic              in_array;
    logic [SUM_W-1:0]  sum_rd;
    logic [SUM_W:0]    acc_sum;
    logic [SUM_W-1:0]  acc_sat;
    logic              f_ok;
    logic [SIZE_W-1:0] bound;
    logic              idx_ok;

    logic [VAL_W-1:0]  mul_b;
    logic [2*VAL_W-1:0] mul_res;
    logic [SUM_W:0]    mul_sum;
    logic              mul_sat;

    logic [SUM_W:0]    shifted;
    logic [SUM_W:0]    trial;
    logic              fits;
    logic              div_ovf;

    // request decode and index checks on the incoming item
    assign sel      = factor_index[SUM_AW-1:0];
    assign in_array = ({1'b0, factor_index} < FACTOR_LIMIT);
    assign sum_rd   = in_array ? sums_reg[sel] : '0;
    assign f_ok     = ({1'b0, factor_index} < n_factors_reg) && in_array;
    assign bound    = (req_type == REQ_SCALE) ? n_rows_reg : n_cols_reg;
    assign idx_ok   = f_ok && ({1'b0, other_index} < bound);
    assign acc_sum  = {1'b0, sum_rd} + {{(SUM_W-VAL_W+1){1'b0}}, elem_value};
    assign acc_sat  = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];

    // one 32x32 multiplier takes the low then the high word of the sum
    assign mul_b   = cmd.mul_hi ? {{(VAL_W-16){1'b0}}, k_reg[SUM_W-1:VAL_W]}
                                : k_reg[VAL_W-1:0];
    assign mul_res = v_reg * mul_b;
    assign mul_sum = {{(SUM_W-VAL_W+1){1'b0}}, hi_reg[15:0], 16'h0000} + {1'b0, lo_reg};
    assign mul_sat = (|hi_reg[SUM_W-1:16]) || (|mul_sum[SUM_W:VAL_W]);

    // restoring divide of elem<<16 by the sum, one quotient bit a cycle
    assign shifted = {rem_reg, quo_reg[VAL_W-1]};
    assign fits    = (shifted >= {1'b0, k_reg});
    assign trial   = shifted - {1'b0, k_reg};
    assign div_ovf = ({{(SUM_W-16){1'b0}}, v_reg[VAL_W-1:16]} >= k_reg);

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_init)
        begin
            rem_next = {{(SUM_W-16){1'b0}}, v_reg[VAL_W-1:16]};
            quo_next = {v_reg[15:0], 16'h0000};
        end
        else if (cmd.div_step)
        begin
            rem_next = fits ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
            quo_next = {quo_reg[VAL_W-2:0], fits};
        end
    end

    always_comb
    begin
        res_next = res_reg;
        st_next  = st_reg;
        if (cmd.load_out)
        begin
            case (cmd.out_sel)
                OUT_MUL:
                begin
                    res_next = mul_sat ? VAL_MAX : mul_sum[VAL_W-1:0];
                    st_next  = (mul_sat || ssat_reg) ? ST_SAT : ST_OK;
                end
                OUT_DIV:
                begin
                    res_next = ovf_reg ? VAL_MAX : quo_reg;
                    st_next  = (ovf_reg || ssat_reg) ? ST_SAT : ST_OK;
                end
                default:
                begin
                    res_next = '0;
                    st_next  = ST_RANGE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_factors_reg <= N_FACTORS_RST;
            n_rows_reg    <= SIZE_RST;
            n_cols_reg    <= SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_N_FACTORS: n_factors_reg <= cfg_data[NF_W-1:0];
                CFG_N_ROWS:    n_rows_reg    <= cfg_data[SIZE_W-1:0];
                CFG_N_COLS:    n_cols_reg    <= cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SUM_DEPTH; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (cmd.capture)
        begin
            if (req_type == REQ_CLEAR)
            begin
                for (int i = 0; i < SUM_DEPTH; i++)
                begin
                    sums_reg[i] <= '0;
                end
            end
            else if ((req_type == REQ_ACC) && idx_ok)
            begin
                sums_reg[sel] <= acc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            v_reg    <= elem_value;
            // a zero sum stands for 1.0
            k_reg    <= (sum_rd == '0) ? ONE_Q16 : sum_rd;
            ssat_reg <= (sum_rd == SUM_MAX);
        end
        if (cmd.mul_lo)
        begin
            lo_reg <= mul_res[2*VAL_W-1:16];
        end
        if (cmd.mul_hi)
        begin
            hi_reg <= mul_res[SUM_W-1:0];
        end
        if (cmd.div_init)
        begin
            ovf_reg <= div_ovf;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
        st_reg  <= st_next;
    end

    assign stat.req      = req_type;
    assign stat.idx_ok   = idx_ok;
    assign stat.div_ovf  = div_ovf;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign status       = st_reg;

endmodule

// ----- src/factor_row_sum_normalizer_core.sv -----
// Factor row-sum normalizer: one request at a time. Accumulate and clear requests
// complete in the cycle they are accepted and produce no result. A scale request
// multiplies the 48-bit sum by the element through one 32x32 multiplier in two
// passes; a normalize request runs a radix-2 divider that produces one of 32
// quotient bits per cycle, and skips the divide when the quotient overflows.
// Requests out of the configured sizes return with status 1.
// The result sits in an output register, so the next request is taken while it
// waits. Sums reset to zero; no clearing pass is needed.
module factor_row_sum_normalizer_core #(
    parameter int MAX_FACTORS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [frsn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frsn_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [frsn_pkg::REQ_W-1:0]      req_type,
    input  logic [frsn_pkg::FIDX_W-1:0]     factor_index,
    input  logic [frsn_pkg::OIDX_W-1:0]     other_index,
    input  logic [frsn_pkg::VAL_W-1:0]      elem_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [frsn_pkg::VAL_W-1:0]      result_value,
    output logic [frsn_pkg::ST_W-1:0]       status
);
    import frsn_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    frsn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    frsn_dp #(
        .MAX_FACTORS (MAX_FACTORS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .factor_index (factor_index),
        .other_index  (other_index),
        .elem_value   (elem_value),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

endmodule

// ----- src/frsn_checker.sv -----
// port-level checks of the normalizer core and their binding
module frsn_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [frsn_pkg::REQ_W-1:0]    req_type,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [frsn_pkg::VAL_W-1:0]    result_value,
    input logic [frsn_pkg::ST_W-1:0]     status
);
    import frsn_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_RANGE) || (status == ST_SAT))
        else $error("undefined status code");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_RANGE) |-> (result_value == '0))
        else $error("range error with nonzero value");

    // accumulate and clear never hold off the next request
    a_quick_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((req_type == REQ_ACC) || (req_type == REQ_CLEAR))
        |=> !in_stall)
        else $error("accumulate or clear left the block busy");

    // a result-producing request keeps the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((req_type == REQ_SCALE) || (req_type == REQ_NORM))
        |=> in_stall)
        else $error("scale or normalize request did not occupy the block");

endmodule

bind factor_row_sum_normalizer_core frsn_checker u_frsn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .status       (status)
);
